/* rtl/rth_pkg.sv */
// Shared constants and pipeline stage types for the RGB to HSV converter.
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned HUE_W       = 15;
    localparam int unsigned NUM_H_W     = 23;
    localparam int unsigned NUM_S_W     = 16;
    localparam int unsigned RECIP_W     = 25;
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned REM_W       = 9;
    localparam int unsigned S_DATA_W    = 32;
    localparam int unsigned M_DATA_W    = 40;

    localparam logic [HUE_W-1:0]   HUE_FULL   = 15'd23040;
    localparam logic [NUM_H_W-1:0] HUE_SECTOR = 23'd3840;
    localparam logic [NUM_S_W-1:0] SAT_SCALE  = 16'd255;

    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] chroma;
        logic [1:0]        sector;
    } stage1_t;

    typedef struct packed {
        logic [NUM_H_W-1:0] num_h;
        logic [NUM_S_W-1:0] num_s;
        logic [RECIP_W-1:0] recip_c;
        logic [RECIP_W-1:0] recip_mx;
        logic [CHAN_W-1:0]  chroma;
        logic [CHAN_W-1:0]  mx;
        logic [CHAN_W-1:0]  alpha;
    } stage2_t;

    typedef struct packed {
        logic [HUE_W-1:0]   q_h;
        logic [CHAN_W-1:0]  q_s;
        logic [NUM_H_W-1:0] num_h;
        logic [NUM_S_W-1:0] num_s;
        logic [CHAN_W-1:0]  chroma;
        logic [CHAN_W-1:0]  mx;
        logic [CHAN_W-1:0]  alpha;
    } stage3_t;

    typedef struct packed {
        logic [HUE_W-1:0]  q_h;
        logic [CHAN_W-1:0] q_s;
        logic [REM_W-1:0]  rem_h;
        logic [REM_W-1:0]  rem_s;
        logic [CHAN_W-1:0] chroma;
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] alpha;
    } stage4_t;

endpackage

`default_nettype wire

/* rtl/rgb_to_hsv_converter.sv */
// Pipelined conversion of RGBA pixels into hue, saturation, value and alpha.
//
// Input words arrive on the s_ stream channel as red, green, blue and alpha
// bytes; results leave on the m_ stream channel as hue in 1/64 degree units,
// saturation scaled to 255, value (the largest channel) and alpha unchanged.
// The converter is a five stage pipeline: a word accepted into stage 1 moves
// on through stages 2, 3 and 4 to the output register that drives m_tdata.
// One word is accepted per cycle in steady state while m_tready stays high.
// The two divisions are done by a 256 entry reciprocal table, a multiplier
// stage and a remainder correction stage, which together set the depth.
// Each stage holds its word until the next stage can take it, so empty
// stages are filled while the receiver stalls and s_tready only falls once
// every stage holds a word. Nothing is lost or repeated during a stall.
// A synchronous active low reset empties the pipeline; no word is presented
// until new input has been accepted.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  wire logic [rth_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hue [14:0], saturation [22:15], brightness [30:23], alpha_out [38:31], zero [39]
    output logic [rth_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_en;

    rth_pkg::stage1_t s1_reg, s1_next;
    rth_pkg::stage2_t s2_reg, s2_next;
    rth_pkg::stage3_t s3_reg, s3_next;
    rth_pkg::stage4_t s4_reg, s4_next;
    logic [rth_pkg::M_DATA_W-1:0] out_reg, out_next;

    logic [rth_pkg::RECIP_W-1:0] recip_rom [256];

    for (genvar i = 0; i < 256; i++) begin : g_recip
        localparam logic [rth_pkg::RECIP_W-1:0] RecipVal = (i == 0) ? '0 :
            rth_pkg::RECIP_W'((33'd1 << rth_pkg::RECIP_SHIFT) / ((i == 0) ? 1 : i));
        assign recip_rom[i] = RecipVal;
    end

    always_comb begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[0] = s_tvalid;
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // Stage 1: largest and smallest channel, chroma and hue sector.
    always_comb begin
        logic [7:0] r, g, b, mx, mn;
        r  = s_tdata[7:0];
        g  = s_tdata[15:8];
        b  = s_tdata[23:16];
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        s1_next.red    = r;
        s1_next.green  = g;
        s1_next.blue   = b;
        s1_next.alpha  = s_tdata[31:24];
        s1_next.mx     = mx;
        s1_next.chroma = mx - mn;
        priority if (mx == r) begin
            s1_next.sector = rth_pkg::SECTOR_RED;
        end else if (mx == g) begin
            s1_next.sector = rth_pkg::SECTOR_GREEN;
        end else begin
            s1_next.sector = rth_pkg::SECTOR_BLUE;
        end
    end

    // Stage 2: hue offset within the circle, numerators and reciprocals.
    always_comb begin
        logic signed [11:0] d;
        logic signed [11:0] c2, c4, c6;
        logic [10:0]        d_u;
        c2 = $signed({3'd0, s1_reg.chroma, 1'b0});
        c4 = $signed({2'd0, s1_reg.chroma, 2'b0});
        c6 = c2 + c4;
        unique case (s1_reg.sector)
            rth_pkg::SECTOR_RED: begin
                d = $signed({4'd0, s1_reg.green}) - $signed({4'd0, s1_reg.blue});
            end
            rth_pkg::SECTOR_GREEN: begin
                d = $signed({4'd0, s1_reg.blue}) - $signed({4'd0, s1_reg.red}) + c2;
            end
            rth_pkg::SECTOR_BLUE: begin
                d = $signed({4'd0, s1_reg.red}) - $signed({4'd0, s1_reg.green}) + c4;
            end
            default: begin
                d = '0;
            end
        endcase
        if (d < 0) begin
            d = d + c6;
        end
        d_u = d[10:0];
        s2_next.num_h    = rth_pkg::NUM_H_W'(d_u) * rth_pkg::HUE_SECTOR;
        s2_next.num_s    = rth_pkg::NUM_S_W'(s1_reg.chroma) * rth_pkg::SAT_SCALE;
        s2_next.recip_c  = recip_rom[s1_reg.chroma];
        s2_next.recip_mx = recip_rom[s1_reg.mx];
        s2_next.chroma   = s1_reg.chroma;
        s2_next.mx       = s1_reg.mx;
        s2_next.alpha    = s1_reg.alpha;
    end

    // Stage 3: quotient estimates, at most one below the true quotient.
    always_comb begin
        logic [47:0] prod_h;
        logic [40:0] prod_s;
        prod_h = 48'(s2_reg.num_h) * 48'(s2_reg.recip_c);
        prod_s = 41'(s2_reg.num_s) * 41'(s2_reg.recip_mx);
        s3_next.q_h    = prod_h[rth_pkg::RECIP_SHIFT +: rth_pkg::HUE_W];
        s3_next.q_s    = prod_s[rth_pkg::RECIP_SHIFT +: rth_pkg::CHAN_W];
        s3_next.num_h  = s2_reg.num_h;
        s3_next.num_s  = s2_reg.num_s;
        s3_next.chroma = s2_reg.chroma;
        s3_next.mx     = s2_reg.mx;
        s3_next.alpha  = s2_reg.alpha;
    end

    // Stage 4: remainders of the estimates, each below twice the divisor.
    always_comb begin
        logic [rth_pkg::NUM_H_W-1:0] back_h, diff_h;
        logic [rth_pkg::NUM_S_W-1:0] back_s, diff_s;
        back_h = rth_pkg::NUM_H_W'(s3_reg.q_h) * rth_pkg::NUM_H_W'(s3_reg.chroma);
        back_s = rth_pkg::NUM_S_W'(s3_reg.q_s) * rth_pkg::NUM_S_W'(s3_reg.mx);
        diff_h = s3_reg.num_h - back_h;
        diff_s = s3_reg.num_s - back_s;
        s4_next.q_h    = s3_reg.q_h;
        s4_next.q_s    = s3_reg.q_s;
        s4_next.rem_h  = diff_h[rth_pkg::REM_W-1:0];
        s4_next.rem_s  = diff_s[rth_pkg::REM_W-1:0];
        s4_next.chroma = s3_reg.chroma;
        s4_next.mx     = s3_reg.mx;
        s4_next.alpha  = s3_reg.alpha;
    end

    // Stage 5: quotient correction, rounding to nearest and special cases.
    always_comb begin
        logic                     h_up, h_half, s_up, s_half;
        logic [rth_pkg::REM_W-1:0] h_rem, s_rem;
        logic [rth_pkg::HUE_W-1:0] h_q;
        logic [8:0]               s_q;
        logic [rth_pkg::HUE_W-1:0] hue;
        logic [7:0]               sat;
        h_up   = s4_reg.rem_h >= {1'b0, s4_reg.chroma};
        h_rem  = h_up ? s4_reg.rem_h - {1'b0, s4_reg.chroma} : s4_reg.rem_h;
        h_half = {h_rem, 1'b0} >= {2'd0, s4_reg.chroma};
        h_q    = s4_reg.q_h + rth_pkg::HUE_W'(h_up) + rth_pkg::HUE_W'(h_half);
        s_up   = s4_reg.rem_s >= {1'b0, s4_reg.mx};
        s_rem  = s_up ? s4_reg.rem_s - {1'b0, s4_reg.mx} : s4_reg.rem_s;
        s_half = {s_rem, 1'b0} >= {2'd0, s4_reg.mx};
        s_q    = {1'b0, s4_reg.q_s} + 9'(s_up) + 9'(s_half);
        if (s4_reg.chroma == '0 || h_q >= rth_pkg::HUE_FULL) begin
            hue = '0;
        end else begin
            hue = h_q;
        end
        if (s4_reg.mx == '0) begin
            sat = '0;
        end else begin
            sat = s_q[7:0];
        end
        out_next = {1'b0, s4_reg.alpha, s4_reg.mx, sat, hue};
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) s1_reg <= s1_next;
        if (stage_en[1]) s2_reg <= s2_next;
        if (stage_en[2]) s3_reg <= s3_next;
        if (stage_en[3]) s4_reg <= s4_next;
        if (stage_en[4]) out_reg <= out_next;
    end

    a_hue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:0] < rth_pkg::HUE_FULL)
        else $error("hue beyond full circle");

    a_black_is_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[30:23] == 8'd0) |-> (m_tdata[22:0] == 23'd0))
        else $error("black pixel with nonzero hue or saturation");

    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_stall_no_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid_reg == '1 && !m_tready))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
